/* hdl/lennard_jones_force_sum_top_macros.svh */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_FORCE_SUM_TOP_MACROS_SVH
`define LENNARD_JONES_FORCE_SUM_TOP_MACROS_SVH

// Same-cycle implication
`define LJ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LJ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lj_pkg.sv */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: package
// Widths, register indexes, shared types and the saturating accumulate.
// ----------------------------------------------------------------------------
package lj_pkg;

	localparam int COORD_BITS    = 24;
	localparam int ACC_BITS      = 48;
	localparam int OUT_BITS      = 48;
	localparam int MAG_BITS      = ACC_BITS - 1;
	localparam int OUT_MAG_BITS  = OUT_BITS - 1;
	localparam int R2_BITS       = 2 * COORD_BITS + 2;
	localparam int U_SHIFT       = 2 * COORD_BITS - 16;
	localparam int W_BITS        = 16;
	localparam int W_FRAC        = 8 + 8;
	localparam int EMIT_SHIFT    = 14;
	localparam int SIGMA_BITS    = 24;
	localparam int EPS_BITS      = 32;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;
	localparam int DIV_BITS      = 96;
	localparam int DIV_CNT_BITS  = $clog2(DIV_BITS);
	localparam int MUL_BITS      = 64;
	localparam int PROD_BITS     = 2 * MUL_BITS;
	localparam int Q_DEPTH       = 4;
	localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

	localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA   = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON = CFG_IDX_BITS'(1);

	typedef struct packed {
		logic [2:0][COORD_BITS-1:0] ad;
		logic [2:0]                 dneg;
		logic [W_BITS-1:0]          aw;
		logic                       wneg;
		logic                       skip;
		logic                       last;
	} lj_item_t;

	typedef struct packed {
		logic     valid;
		lj_item_t item;
	} lj_queue_t;

	typedef struct packed {
		logic                start;
		logic [MUL_BITS-1:0] a;
		logic [MUL_BITS-1:0] b;
	} lj_mul_req_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] num;
		logic [R2_BITS-1:0]  den;
	} lj_div_req_t;

	typedef struct packed {
		logic signed [ACC_BITS-1:0] sum;
		logic                       sat;
	} lj_acc_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SQ_GO, S_SQ_WAIT, S_SS_GO, S_SS_WAIT, S_UDIV_GO, S_UDIV_WAIT,
		S_U2_GO, S_U2_WAIT, S_U3_GO, S_U3_WAIT, S_U6_GO, S_U6_WAIT,
		S_EN_GO, S_EN_WAIT, S_G_GO, S_G_WAIT, S_FN_GO, S_FN_WAIT,
		S_FDIV_GO, S_FDIV_WAIT, S_LAST, S_EM_GO, S_EM_WAIT, S_OUT
	} lj_state_t;

	// Add a signed magnitude to a sum, clamping symmetrically at +-(2^(ACC_BITS-1)-1)
	function automatic lj_acc_t acc_add(input logic signed [ACC_BITS-1:0] acc,
			input logic [MAG_BITS-1:0] mag, input logic neg);
		logic signed [ACC_BITS:0] lim;
		logic signed [ACC_BITS:0] nlim;
		logic signed [ACC_BITS:0] t;
		logic signed [ACC_BITS:0] s;
		lj_acc_t r;
		lim  = $signed({2'b00, {MAG_BITS{1'b1}}});
		nlim = -lim;
		t    = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
		s    = $signed({acc[ACC_BITS-1], acc}) + t;
		r.sat = 1'b0;
		if (s > lim) begin
			r.sum = lim[ACC_BITS-1:0];
			r.sat = 1'b1;
		end else if (s < nlim) begin
			r.sum = nlim[ACC_BITS-1:0];
			r.sat = 1'b1;
		end else begin
			r.sum = s[ACC_BITS-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/lj_front.sv */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: front end
// Accepts pairs, forms separations and weight magnitude, queues the items.
// ----------------------------------------------------------------------------
`include "lennard_jones_force_sum_top_macros.svh"

module lj_front import lj_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic [COORD_BITS-1:0]    target_x,
	input  logic [COORD_BITS-1:0]    target_y,
	input  logic [COORD_BITS-1:0]    target_z,
	input  logic [COORD_BITS-1:0]    source_x,
	input  logic [COORD_BITS-1:0]    source_y,
	input  logic [COORD_BITS-1:0]    source_z,
	input  logic signed [W_BITS-1:0] source_weight,
	input  logic                     last_source,
	output lj_queue_t                queue,
	input  logic                     pop
);

	logic [2:0][COORD_BITS-1:0] tgt;
	logic [2:0][COORD_BITS-1:0] src;
	logic [2:0][COORD_BITS:0]   diff;
	lj_item_t                   cls;
	lj_item_t                   mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]      wr_ptr_q;
	logic [Q_PTR_BITS-1:0]      rd_ptr_q;
	logic [Q_CNT_BITS-1:0]      count_q;
	logic                       push;

	assign tgt = {target_z, target_y, target_x};
	assign src = {source_z, source_y, source_x};

	// Classify the pair: per-axis magnitude and sign, zero separation, weight magnitude
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i]        = {1'b0, tgt[i]} - {1'b0, src[i]};
			cls.dneg[i]    = diff[i][COORD_BITS];
			cls.ad[i]      = diff[i][COORD_BITS] ? COORD_BITS'(-diff[i])
			                                     : diff[i][COORD_BITS-1:0];
		end
		cls.skip = (cls.ad[0] | cls.ad[1] | cls.ad[2]) == '0;
		cls.wneg = source_weight[W_BITS-1];
		cls.aw   = source_weight[W_BITS-1] ? W_BITS'(-source_weight)
		                                   : W_BITS'(source_weight);
		cls.last = last_source;
	end

	assign item_stall  = count_q == Q_CNT_BITS'(Q_DEPTH);
	assign push        = item_valid && !item_stall;
	assign queue.valid = count_q != '0;
	assign queue.item  = mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + Q_CNT_BITS'(push) - Q_CNT_BITS'(pop);
		end
	end

	`LJ_ASSERT_IMP(a_pop_not_empty, pop, count_q != '0, "item popped from empty queue")
	`LJ_ASSERT_NXT(a_fill_moves, push && !pop, count_q != '0, "queue fill lost a push")

endmodule

/* hdl/lj_mul.sv */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: shared multiplier
// 64 x 64 product built from four 32 x 32 partial products, one a cycle.
// ----------------------------------------------------------------------------
module lj_mul import lj_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lj_mul_req_t          req,
	output logic [PROD_BITS-1:0] prod,
	output logic                 done
);

	localparam int HALF = MUL_BITS / 2;

	logic [MUL_BITS-1:0]  a_q;
	logic [MUL_BITS-1:0]  b_q;
	logic [PROD_BITS-1:0] acc_q;
	logic [1:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [HALF-1:0]      a_part;
	logic [HALF-1:0]      b_part;
	logic [MUL_BITS-1:0]  pp;
	logic [1:0]           pos;

	// Pick the partial product for this step
	assign a_part = cnt_q[0] ? a_q[MUL_BITS-1:HALF] : a_q[HALF-1:0];
	assign b_part = cnt_q[1] ? b_q[MUL_BITS-1:HALF] : b_q[HALF-1:0];
	assign pp     = a_part * b_part;
	assign pos    = 2'(cnt_q[0]) + 2'(cnt_q[1]);

	assign prod = acc_q;
	assign done = done_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + (PROD_BITS'(pp) << {pos, 5'b00000});
		end
	end

	// Step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* hdl/lj_div.sv */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: shared divider
// Restoring division, one quotient bit a cycle over the full numerator.
// ----------------------------------------------------------------------------
module lj_div import lj_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lj_div_req_t         req,
	output logic [DIV_BITS-1:0] quo,
	output logic                done
);

	logic [DIV_BITS-1:0]     nq_q;
	logic [R2_BITS-1:0]      den_q;
	logic [R2_BITS-1:0]      rem_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [R2_BITS:0]        rem_sh;
	logic                    ge;
	logic [R2_BITS:0]        rem_sub;

	// One restoring step
	assign rem_sh  = {rem_q, nq_q[DIV_BITS-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	assign quo  = nq_q;
	assign done = done_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q  <= {nq_q[DIV_BITS-2:0], ge};
			rem_q <= ge ? rem_sub[R2_BITS-1:0] : rem_sh[R2_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* hdl/lj_back.sv */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: back end
// Sequences the shared multiplier and divider per item, accumulates, emits.
// ----------------------------------------------------------------------------
`include "lennard_jones_force_sum_top_macros.svh"

module lj_back import lj_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lj_queue_t                  queue,
	output logic                       pop,
	input  logic [SIGMA_BITS-1:0]      sigma,
	input  logic [EPS_BITS-1:0]        epsilon,
	output lj_mul_req_t                mul_req,
	input  logic [PROD_BITS-1:0]       mul_p,
	input  logic                       mul_done,
	output lj_div_req_t                div_req,
	input  logic [DIV_BITS-1:0]        div_quo,
	input  logic                       div_done,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [OUT_BITS-1:0] force_x,
	output logic signed [OUT_BITS-1:0] force_y,
	output logic signed [OUT_BITS-1:0] force_z,
	output logic signed [OUT_BITS-1:0] energy,
	output logic                       saturated
);

	localparam int U_BITS = MUL_BITS;
	localparam int G_BITS = U_BITS + 4;

	lj_state_t                  state_q, state_d;
	logic [1:0]                 k_q;
	lj_item_t                   item_q;
	logic [R2_BITS-1:0]         r2_q;
	logic [U_BITS-1:0]          u_q, u2_q, u3_q, u6_q;
	logic [MAG_BITS-1:0]        gmag_q;
	logic                       gneg_q;
	logic signed [ACC_BITS-1:0] sum_q [4];
	logic                       sat_q;
	logic signed [OUT_BITS-1:0] res_q [4];
	logic                       result_valid_q;
	logic signed [OUT_BITS-1:0] force_x_q, force_y_q, force_z_q, energy_q;
	logic                       saturated_q;
	logic                       out_load;

	logic                       dneg_e;
	logic [U_BITS-1:0]          dm;
	logic [G_BITS-1:0]          a12, b6, gm;
	logic                       gneg0;
	logic [W_BITS+3:0]          gm_hi_prod;
	logic [PROD_BITS-1:0]       gw;
	logic                       mq_sat;
	logic [U_BITS-1:0]          mq_val;
	logic                       em_sat;
	logic [MAG_BITS-1:0]        em_mag;
	logic                       gm_sat;
	logic                       fm_sat;
	logic [MAG_BITS-1:0]        fm_mag;
	logic                       om_sat;
	logic [OUT_MAG_BITS-1:0]    om_mag;
	logic signed [ACC_BITS-1:0] sum_sel;
	logic [ACC_BITS-1:0]        sum_abs;
	lj_acc_t                    acc_e, acc_f;

	// Energy and force-scale terms from the powers of u
	assign dneg_e     = u6_q < u3_q;
	assign dm         = dneg_e ? u3_q - u6_q : u6_q - u3_q;
	assign a12        = (G_BITS'(u6_q) << 3) + (G_BITS'(u6_q) << 2);
	assign b6         = (G_BITS'(u3_q) << 2) + (G_BITS'(u3_q) << 1);
	assign gneg0      = a12 < b6;
	assign gm         = gneg0 ? b6 - a12 : a12 - b6;
	assign gm_hi_prod = gm[G_BITS-1:U_BITS] * item_q.aw;
	assign gw         = mul_p + PROD_BITS'({gm_hi_prod, {U_BITS{1'b0}}});

	// Clamp the products and quotients
	assign mq_sat = |mul_p[PROD_BITS-1:U_BITS+32];
	assign mq_val = mq_sat ? {U_BITS{1'b1}} : mul_p[U_BITS+31:32];
	assign em_sat = |mul_p[PROD_BITS-1:MAG_BITS+W_FRAC];
	assign em_mag = em_sat ? {MAG_BITS{1'b1}} : mul_p[MAG_BITS+W_FRAC-1:W_FRAC];
	assign gm_sat = |gw[PROD_BITS-1:MAG_BITS+W_FRAC];
	assign fm_sat = |div_quo[DIV_BITS-1:MAG_BITS];
	assign fm_mag = fm_sat ? {MAG_BITS{1'b1}} : div_quo[MAG_BITS-1:0];
	assign om_sat = |mul_p[PROD_BITS-1:OUT_MAG_BITS+EMIT_SHIFT];
	assign om_mag = om_sat ? {OUT_MAG_BITS{1'b1}}
	                       : mul_p[OUT_MAG_BITS+EMIT_SHIFT-1:EMIT_SHIFT];

	assign sum_sel = sum_q[k_q];
	assign sum_abs = sum_sel[ACC_BITS-1] ? ACC_BITS'(-sum_sel) : ACC_BITS'(sum_sel);
	assign acc_e   = acc_add(sum_q[3], em_mag, dneg_e ^ item_q.wneg);
	assign acc_f   = acc_add(sum_sel, fm_mag, gneg_q ^ item_q.dneg[k_q]);

	assign out_load = (state_q == S_OUT) && (!result_valid_q || !result_stall);

	// Next state and unit requests
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		mul_req = '0;
		div_req = '0;
		case (state_q)
			S_IDLE: begin
				if (queue.valid) begin
					pop     = 1'b1;
					state_d = queue.item.skip ? S_LAST : S_SQ_GO;
				end
			end
			S_SQ_GO: begin
				mul_req = '{1'b1, MUL_BITS'(item_q.ad[k_q]), MUL_BITS'(item_q.ad[k_q])};
				state_d = S_SQ_WAIT;
			end
			S_SQ_WAIT: if (mul_done) state_d = (k_q == 2'd2) ? S_SS_GO : S_SQ_GO;
			S_SS_GO: begin
				mul_req = '{1'b1, MUL_BITS'(sigma), MUL_BITS'(sigma)};
				state_d = S_SS_WAIT;
			end
			S_SS_WAIT: if (mul_done) state_d = S_UDIV_GO;
			S_UDIV_GO: begin
				div_req = '{1'b1, DIV_BITS'(mul_p) << U_SHIFT, r2_q};
				state_d = S_UDIV_WAIT;
			end
			S_UDIV_WAIT: if (div_done) state_d = S_U2_GO;
			S_U2_GO: begin
				mul_req = '{1'b1, u_q, u_q};
				state_d = S_U2_WAIT;
			end
			S_U2_WAIT: if (mul_done) state_d = S_U3_GO;
			S_U3_GO: begin
				mul_req = '{1'b1, u2_q, u_q};
				state_d = S_U3_WAIT;
			end
			S_U3_WAIT: if (mul_done) state_d = S_U6_GO;
			S_U6_GO: begin
				mul_req = '{1'b1, u3_q, u3_q};
				state_d = S_U6_WAIT;
			end
			S_U6_WAIT: if (mul_done) state_d = S_EN_GO;
			S_EN_GO: begin
				mul_req = '{1'b1, dm, MUL_BITS'(item_q.aw)};
				state_d = S_EN_WAIT;
			end
			S_EN_WAIT: if (mul_done) state_d = S_G_GO;
			S_G_GO: begin
				mul_req = '{1'b1, gm[U_BITS-1:0], MUL_BITS'(item_q.aw)};
				state_d = S_G_WAIT;
			end
			S_G_WAIT: if (mul_done) state_d = S_FN_GO;
			S_FN_GO: begin
				mul_req = '{1'b1, MUL_BITS'(gmag_q), MUL_BITS'(item_q.ad[k_q])};
				state_d = S_FN_WAIT;
			end
			S_FN_WAIT: if (mul_done) state_d = S_FDIV_GO;
			S_FDIV_GO: begin
				div_req = '{1'b1, DIV_BITS'(mul_p) << COORD_BITS, r2_q};
				state_d = S_FDIV_WAIT;
			end
			S_FDIV_WAIT: if (div_done) state_d = (k_q == 2'd2) ? S_LAST : S_FN_GO;
			S_LAST: state_d = item_q.last ? S_EM_GO : S_IDLE;
			S_EM_GO: begin
				mul_req = '{1'b1, MUL_BITS'(sum_abs), MUL_BITS'(epsilon)};
				state_d = S_EM_WAIT;
			end
			S_EM_WAIT: if (mul_done) state_d = (k_q == 2'd3) ? S_OUT : S_EM_GO;
			S_OUT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working values of the current item
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					item_q <= queue.item;
					r2_q   <= '0;
				end
			end
			S_SQ_WAIT: if (mul_done) r2_q <= r2_q + R2_BITS'(mul_p);
			S_UDIV_WAIT: begin
				if (div_done) begin
					u_q <= (|div_quo[DIV_BITS-1:U_BITS]) ? {U_BITS{1'b1}}
					                                     : div_quo[U_BITS-1:0];
				end
			end
			S_U2_WAIT: if (mul_done) u2_q <= mq_val;
			S_U3_WAIT: if (mul_done) u3_q <= mq_val;
			S_U6_WAIT: if (mul_done) u6_q <= mq_val;
			S_G_WAIT: begin
				if (mul_done) begin
					gmag_q <= gm_sat ? {MAG_BITS{1'b1}}
					                 : gw[MAG_BITS+W_FRAC-1:W_FRAC];
					gneg_q <= gneg0 ^ item_q.wneg;
				end
			end
			S_EM_WAIT: begin
				if (mul_done) begin
					res_q[k_q] <= sum_sel[ACC_BITS-1] ? -$signed({1'b0, om_mag})
					                                  : $signed({1'b0, om_mag});
				end
			end
			default: ;
		endcase
	end

	// Loop index, sums and saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			sat_q <= 1'b0;
			for (int i = 0; i < 4; i++) sum_q[i] <= '0;
		end else begin
			case (state_q)
				S_IDLE: k_q <= '0;
				S_SQ_WAIT: if (mul_done) k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
				S_UDIV_WAIT: if (div_done && |div_quo[DIV_BITS-1:U_BITS]) sat_q <= 1'b1;
				S_U2_WAIT, S_U3_WAIT, S_U6_WAIT: if (mul_done && mq_sat) sat_q <= 1'b1;
				S_EN_WAIT: begin
					if (mul_done) begin
						sum_q[3] <= acc_e.sum;
						if (em_sat || acc_e.sat) sat_q <= 1'b1;
					end
				end
				S_G_WAIT: begin
					k_q <= '0;
					if (mul_done && gm_sat) sat_q <= 1'b1;
				end
				S_FDIV_WAIT: begin
					if (div_done) begin
						sum_q[k_q] <= acc_f.sum;
						if (fm_sat || acc_f.sat) sat_q <= 1'b1;
						k_q <= k_q + 1'b1;
					end
				end
				S_LAST: k_q <= '0;
				S_EM_WAIT: begin
					if (mul_done) begin
						k_q <= k_q + 1'b1;
						if (om_sat) sat_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_load) begin
						sat_q <= 1'b0;
						for (int i = 0; i < 4; i++) sum_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			force_x_q   <= res_q[0];
			force_y_q   <= res_q[1];
			force_z_q   <= res_q[2];
			energy_q    <= res_q[3];
			saturated_q <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign force_x      = force_x_q;
	assign force_y      = force_y_q;
	assign force_z      = force_z_q;
	assign energy       = energy_q;
	assign saturated    = saturated_q;

	`LJ_ASSERT_NXT(a_emit_clears, out_load, (sum_q[3] == '0) && !sat_q, "sums kept after emit")
	`LJ_ASSERT_IMP(a_energy_sym, 1'b1, sum_q[3] != {1'b1, {MAG_BITS{1'b0}}}, "asymmetric clamp")
	`LJ_ASSERT_IMP(a_mul_div_excl, mul_req.start, !div_req.start, "units started together")

endmodule

/* hdl/lennard_jones_force_sum_top.sv */
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: top level
// Configuration registers, front-end queue, back-end sequencer and units.
// ----------------------------------------------------------------------------
// One pair is taken per item into a four-deep queue; the back end works on one
// item at a time on a shared 32 x 32 multiplier (four partial products per 64-bit
// product) and a one-bit-per-cycle 96-step divider. A pair with zero separation
// skips the arithmetic in the back end; any other pair needs four 96-step
// divisions (one for u, one per axis). A last-source item adds the four epsilon
// products. The input side keeps accepting until the queue fills, and a finished
// result waits in its own register.

module lennard_jones_force_sum_top import lj_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [COORD_BITS-1:0]      target_x,
	input  logic [COORD_BITS-1:0]      target_y,
	input  logic [COORD_BITS-1:0]      target_z,
	input  logic [COORD_BITS-1:0]      source_x,
	input  logic [COORD_BITS-1:0]      source_y,
	input  logic [COORD_BITS-1:0]      source_z,
	input  logic signed [W_BITS-1:0]   source_weight,
	input  logic                       last_source,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [OUT_BITS-1:0] force_x,
	output logic signed [OUT_BITS-1:0] force_y,
	output logic signed [OUT_BITS-1:0] force_z,
	output logic signed [OUT_BITS-1:0] energy,
	output logic                       saturated
);

	logic [SIGMA_BITS-1:0] sigma_q;
	logic [EPS_BITS-1:0]   epsilon_q;
	lj_queue_t             queue;
	logic                  pop;
	lj_mul_req_t           mul_req;
	logic [PROD_BITS-1:0]  mul_p;
	logic                  mul_done;
	lj_div_req_t           div_req;
	logic [DIV_BITS-1:0]   div_quo;
	logic                  div_done;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q   <= '0;
			epsilon_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SIGMA) sigma_q <= cfg_data[SIGMA_BITS-1:0];
			if (cfg_index == REG_EPSILON) epsilon_q <= cfg_data[EPS_BITS-1:0];
		end
	end

	lj_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.target_x      (target_x),
		.target_y      (target_y),
		.target_z      (target_z),
		.source_x      (source_x),
		.source_y      (source_y),
		.source_z      (source_z),
		.source_weight (source_weight),
		.last_source   (last_source),
		.queue         (queue),
		.pop           (pop)
	);

	lj_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.prod   (mul_p),
		.done   (mul_done)
	);

	lj_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.quo    (div_quo),
		.done   (div_done)
	);

	lj_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue        (queue),
		.pop          (pop),
		.sigma        (sigma_q),
		.epsilon      (epsilon_q),
		.mul_req      (mul_req),
		.mul_p        (mul_p),
		.mul_done     (mul_done),
		.div_req      (div_req),
		.div_quo      (div_quo),
		.div_done     (div_done),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.force_x      (force_x),
		.force_y      (force_y),
		.force_z      (force_z),
		.energy       (energy),
		.saturated    (saturated)
	);

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lennard-Jones force sum: testbench
// Streams target/source pairs into the block and predicts each per-target
// force and energy increment with an in-bench fixed-point model. Every result
// is checked field by field against the queue of predicted increments.
// ----------------------------------------------------------------------------
module testbench import lj_pkg::*;;

	localparam int    RUN_LIMIT  = 6000000;
	localparam int    SETTLE     = 600;
	localparam logic [63:0] ACC_LIM = (64'd1 << (ACC_BITS - 1)) - 1;
	localparam logic [63:0] OUT_LIM = (64'd1 << (OUT_BITS - 1)) - 1;
	localparam logic [63:0] U_LIM   = {64{1'b1}};

	typedef struct {
		logic [OUT_BITS-1:0] fx, fy, fz, en;
		logic                sat;
	} lj_incr_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic [COORD_BITS-1:0] target_x, target_y, target_z;
	logic [COORD_BITS-1:0] source_x, source_y, source_z;
	logic signed [W_BITS-1:0] source_weight;
	logic last_source;
	logic result_valid;
	logic result_stall;
	logic signed [OUT_BITS-1:0] force_x, force_y, force_z, energy;
	logic saturated;

	// predictor copy of registers and sums
	logic [63:0] mdl_sigma, mdl_eps;
	logic signed [63:0] mdl_sum [4];
	logic mdl_sat;

	lj_incr_t pending_incr [$];
	int unsigned n_errors, n_results, n_items, cycles, stall_left;
	bit calm;

	lennard_jones_force_sum_top u_dut (.*);

	// clock
	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result stall in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (calm) begin
			result_stall <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			result_stall <= 1'b1;
			stall_left   <= $urandom_range(0, 10);
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
		n_errors++;
	endtask

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		lj_incr_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_incr.size() == 0) begin
				report("unexpected result", 64'(force_x), 64'd0);
			end else begin
				w = pending_incr.pop_front();
				if (force_x !== w.fx) report("force_x", 64'(force_x), 64'(w.fx));
				if (force_y !== w.fy) report("force_y", 64'(force_y), 64'(w.fy));
				if (force_z !== w.fz) report("force_z", 64'(force_z), 64'(w.fz));
				if (energy !== w.en) report("energy", 64'(energy), 64'(w.en));
				if (saturated !== w.sat) report("saturated", 64'(saturated), 64'(w.sat));
			end
			n_results++;
		end
	end

	// clamp a magnitude, noting saturation
	function automatic logic [63:0] clamp_mag(input logic [127:0] v, input logic [63:0] mx);
		if (v > {64'd0, mx}) begin
			mdl_sat = 1'b1;
			return mx;
		end
		return v[63:0];
	endfunction

	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return clamp_mag(p >> 32, U_LIM);
	endfunction

	function automatic void accumulate(input int k, input logic [63:0] mag, input bit neg);
		logic signed [63:0] s;
		s = neg ? mdl_sum[k] - $signed(mag) : mdl_sum[k] + $signed(mag);
		if (s > $signed(ACC_LIM)) begin
			s = $signed(ACC_LIM);
			mdl_sat = 1'b1;
		end else if (s < -$signed(ACC_LIM)) begin
			s = -$signed(ACC_LIM);
			mdl_sat = 1'b1;
		end
		mdl_sum[k] = s;
	endfunction

	function automatic logic [OUT_BITS-1:0] scale_out(input logic signed [63:0] sum);
		bit neg;
		logic [63:0] m, om;
		logic [127:0] p;
		neg = sum < 0;
		m   = neg ? -sum : sum;
		p   = {64'd0, m} * {64'd0, mdl_eps};
		om  = clamp_mag(p >> EMIT_SHIFT, OUT_LIM);
		return neg ? OUT_BITS'(-om) : OUT_BITS'(om);
	endfunction

	// fold one pair into the sums; return 1 with the increment on the last source
	function automatic bit predict_pair(input logic [COORD_BITS-1:0] t [3],
			input logic [COORD_BITS-1:0] s [3], input logic [15:0] w, input bit last,
			output lj_incr_t r);
		logic signed [31:0] d [3];
		logic [63:0] ad [3];
		logic [127:0] r2, num, a, b, gm, n;
		logic [63:0] u, u2, u3, u6, dm, em, gmag, fm, aw;
		bit wneg, dneg, gneg;
		for (int i = 0; i < 3; i++) begin
			d[i]  = $signed({8'd0, t[i]}) - $signed({8'd0, s[i]});
			ad[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
		end
		if ((ad[0] | ad[1] | ad[2]) != 0) begin
			wneg = w[15];
			aw   = wneg ? 64'h10000 - 64'(w) : 64'(w);
			r2   = 128'(ad[0] * ad[0]) + 128'(ad[1] * ad[1]) + 128'(ad[2] * ad[2]);
			num  = 128'(mdl_sigma * mdl_sigma) << U_SHIFT;
			u    = clamp_mag(num / r2, U_LIM);
			u2   = mul_q32(u, u);
			u3   = mul_q32(u2, u);
			u6   = mul_q32(u3, u3);
			dneg = u6 < u3;
			dm   = dneg ? u3 - u6 : u6 - u3;
			em   = clamp_mag(({64'd0, dm} * {64'd0, aw}) >> 16, ACC_LIM);
			accumulate(3, em, dneg != wneg);
			a    = {64'd0, u6} * 128'd12;
			b    = {64'd0, u3} * 128'd6;
			gneg = a < b;
			gm   = gneg ? b - a : a - b;
			gmag = clamp_mag((gm * {64'd0, aw}) >> 16, ACC_LIM);
			gneg = gneg != wneg;
			for (int i = 0; i < 3; i++) begin
				n  = ({64'd0, gmag} * {64'd0, ad[i]}) << COORD_BITS;
				fm = clamp_mag(n / r2, ACC_LIM);
				accumulate(i, fm, gneg != (d[i] < 0));
			end
		end
		if (!last) return 0;
		r.fx  = scale_out(mdl_sum[0]);
		r.fy  = scale_out(mdl_sum[1]);
		r.fz  = scale_out(mdl_sum[2]);
		r.en  = scale_out(mdl_sum[3]);
		r.sat = mdl_sat;
		for (int k = 0; k < 4; k++) mdl_sum[k] = 0;
		mdl_sat = 1'b0;
		return 1;
	endfunction

	// send one item, predict on acceptance, then maybe idle
	task automatic send_pair(input logic [COORD_BITS-1:0] t [3],
			input logic [COORD_BITS-1:0] s [3], input logic [15:0] w, input bit last);
		lj_incr_t r;
		int gap;
		target_x      <= t[0];
		target_y      <= t[1];
		target_z      <= t[2];
		source_x      <= s[0];
		source_y      <= s[1];
		source_z      <= s[2];
		source_weight <= w;
		last_source   <= last;
		item_valid    <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (predict_pair(t, s, w, last, r)) pending_incr.push_back(r);
		n_items++;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every increment is back and the back end is quiet
	task automatic drain();
		item_valid <= 1'b0;
		while (pending_incr.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_SIGMA) mdl_sigma = 64'(val[SIGMA_BITS-1:0]);
		else if (idx == REG_EPSILON) mdl_eps = 64'(val);
	endtask

	task automatic set_params(input logic [31:0] sg, input logic [31:0] ep);
		drain();
		write_reg(REG_SIGMA, sg);
		write_reg(REG_EPSILON, ep);
	endtask

	// source near the target at a random scale, or anywhere, or on top of it
	task automatic random_pair(input bit last);
		logic [COORD_BITS-1:0] t [3], s [3];
		int k, mode;
		mode = $urandom_range(0, 9);
		k    = $urandom_range(0, COORD_BITS - 1);
		for (int i = 0; i < 3; i++) begin
			t[i] = COORD_BITS'($urandom);
			if (mode < 5) s[i] = t[i] + COORD_BITS'($urandom_range(0, 1 << k))
					- COORD_BITS'($urandom_range(0, 1 << k));
			else if (mode < 8) s[i] = COORD_BITS'($urandom);
			else s[i] = t[i];
		end
		send_pair(t, s, 16'($urandom), last);
	endtask

	// groups of pairs that each end in a last source
	task automatic random_groups(input int count);
		int left, len;
		left = count;
		while (left > 0) begin
			len = $urandom_range(1, 6);
			if (len > left) len = left;
			for (int j = 0; j < len; j++) random_pair(j == len - 1);
			left -= len;
		end
	endtask

	task automatic test_reset_values();
		logic [COORD_BITS-1:0] t [3], s [3];
		t = '{24'h100000, 24'h200000, 24'h300000};
		s = '{24'h100010, 24'h1FFFF0, 24'h300000};
		send_pair(t, s, 16'h0100, 1'b1);
		random_groups(10);
	endtask

	task automatic test_directed();
		logic [COORD_BITS-1:0] t [3], s [3];
		logic [COORD_BITS-1:0] zmax [3], zmin [3];
		zmax = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		zmin = '{24'h0, 24'h0, 24'h0};
		set_params(32'h040000, 32'h00010000);
		// zero separation alone ends a target
		send_pair(zmax, zmax, 16'h7FFF, 1'b1);
		send_pair(zmin, zmin, 16'h8000, 1'b1);
		// widest separation, both ways, extreme weights
		send_pair(zmax, zmin, 16'h7FFF, 1'b0);
		send_pair(zmin, zmax, 16'h8000, 1'b1);
		// zero separation in the middle of a target
		t = '{24'h400000, 24'h400000, 24'h400000};
		s = '{24'h440000, 24'h400000, 24'h3C0000};
		send_pair(t, s, 16'h0100, 1'b0);
		send_pair(t, t, 16'h0100, 1'b0);
		send_pair(t, s, 16'hFF00, 1'b1);
		// zero weight
		send_pair(t, s, 16'h0000, 1'b1);
		// separation near sigma, single axis
		s = '{24'h440000, 24'h400000, 24'h400000};
		send_pair(t, s, 16'h0180, 1'b1);
		// tiny separation: powers of u and the sums saturate
		s = '{24'h400001, 24'h400000, 24'h400000};
		send_pair(t, s, 16'h7FFF, 1'b0);
		send_pair(t, s, 16'h7FFF, 1'b1);
		send_pair(t, s, 16'h8000, 1'b1);
		// the flag clears after a result
		s = '{24'h480000, 24'h380000, 24'h400000};
		send_pair(t, s, 16'h0100, 1'b1);
		// largest sigma and epsilon drive the outputs to their clamp
		set_params(32'hFFFFFF, 32'hFFFFFFFF);
		s = '{24'h500000, 24'h400000, 24'h400000};
		send_pair(t, s, 16'h0100, 1'b1);
		send_pair(t, s, 16'hFF00, 1'b1);
		send_pair(zmax, zmin, 16'h8000, 1'b1);
	endtask

	task automatic test_param_sweep();
		set_params(32'h000000, 32'h00010000);
		random_groups(250);
		set_params(32'hFFFFFF, 32'h00000000);
		random_groups(250);
		set_params(32'h020000, 32'hFFFFFFFF);
		random_groups(300);
		// pause until every increment has come back, then carry on
		drain();
		random_groups(20);
		set_params(32'h008000 + ($urandom & 32'h3FFFF), $urandom);
		random_groups(400);
		set_params($urandom, 32'h00000000 + $urandom_range(1, 32'h20000));
		random_groups(300);
	endtask

	task automatic test_no_idling();
		set_params(32'h010000, 32'h00040000);
		calm = 1'b1;
		random_groups(400);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		item_valid    = 1'b0;
		target_x      = '0;
		target_y      = '0;
		target_z      = '0;
		source_x      = '0;
		source_y      = '0;
		source_z      = '0;
		source_weight = '0;
		last_source   = 1'b0;
		calm          = 1'b0;
		cycles        = 0;
		n_errors      = 0;
		n_results     = 0;
		n_items       = 0;
		mdl_sigma     = 0;
		mdl_eps       = 0;
		mdl_sat       = 1'b0;
		for (int k = 0; k < 4; k++) mdl_sum[k] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_param_sweep();
		test_no_idling();

		drain();
		$display("run covered %0d pairs and %0d target increments over %0d cycles",
			n_items, n_results, cycles);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
